### rtl/aspect_ratio_run_scaler_top_macros.svh
// ----------------------------------------------------------------------------
// aspect ratio run scaler assertion macros
// concurrent assertion wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASPECT_RATIO_RUN_SCALER_TOP_MACROS_SVH
`define ASPECT_RATIO_RUN_SCALER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ARSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("arsc assertion failed");
`define ARSC_ASSERT_STALL(lbl, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("arsc stall assertion failed");
`else
`define ARSC_ASSERT(lbl, prop)
`define ARSC_ASSERT_STALL(lbl, cond, sig)
`endif
`endif

### rtl/arsc_pkg.sv
// ----------------------------------------------------------------------------
// arsc_pkg
// shared types and constants of the aspect ratio run scaler
// ----------------------------------------------------------------------------
package arsc_pkg;

  localparam int RUN_W    = 9;
  localparam int CHAR_W   = 7;
  localparam int CNT_W    = 10;
  localparam int RATIO_W  = 18;
  localparam int FRAC_MAX = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  typedef logic [1:0] dot_kind_t;

  localparam dot_kind_t KIND_WHITE = 2'd0;
  localparam dot_kind_t KIND_BLACK = 2'd1;
  localparam dot_kind_t KIND_EOL   = 2'd2;
  localparam dot_kind_t KIND_ALT   = 2'd3;

  localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
  localparam logic [CHAR_W-1:0] CH_HASH  = 7'd35;
  localparam logic [CHAR_W-1:0] CH_OH    = 7'd79;
  localparam logic [CHAR_W-1:0] CH_LPAR  = 7'd40;
  localparam logic [CHAR_W-1:0] CH_RPAR  = 7'd41;
  localparam logic [CHAR_W-1:0] CH_NL    = 7'd10;

  localparam logic [CNT_W-1:0]   COUNT_MAX   = 10'd1023;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 18'd108790;

  localparam logic [CFG_IDX_W-1:0] REG_ACCURATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO    = 2'd1;

  // run end or blank line event from the classifier
  typedef struct packed {
    logic             nl_only;
    logic             first;
    logic             prev_black;
    logic             next_black;
    logic             eol;
    logic [RUN_W-1:0] run_len;
  } arsc_event_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [CNT_W-1:0]  repeat_count;
  } arsc_slot_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [CNT_W-1:0]  repeat_count;
    logic              last_of_burst;
  } arsc_result_t;

endpackage

### rtl/aspect_ratio_run_scaler_top.sv
// ----------------------------------------------------------------------------
// aspect_ratio_run_scaler_top
// banner dot stream to scaled character runs
// ----------------------------------------------------------------------------
// Input is a queue side: drive in_dot_kind with in_push, an item is taken
// when in_full is low. Each dot is white, black or end of line. Results come
// out as a queue: while out_empty is low the oldest result (character, repeat
// count, last of burst flag) is on the out ports, and out_pop takes it.
// Registers are written through cfg_valid/cfg_ready (ready is always high);
// write them only while the block is idle, the block does not enforce it.
// One dot is taken per cycle while in_full is low. A dot that ends a run or a
// line gives zero to three results, which pass through the event queue, the
// multiply stage, the burst registers and the result queue. Results leave at
// one per cycle while out_pop is high, so the output port sets the pace.
// The classifier and the scaling pipeline are split by a 4 entry event queue,
// and a 4 entry result queue sits before the outputs; when the receiver
// stalls the queues fill and in_full rises. Reset clears all queues and
// state, sets compact style and the default ratio of 1.66.
// ----------------------------------------------------------------------------
module aspect_ratio_run_scaler_top
  import arsc_pkg::*;
#(
  parameter int MAX_RUN   = 255,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [1:0]           in_dot_kind,
  output logic                 in_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [CHAR_W-1:0]    out_char_code,
  output logic [CNT_W-1:0]     out_repeat_count,
  output logic                 out_last_of_burst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATIO_W-1:0]   cfg_data
);

  logic               accurate_r;
  logic [RATIO_W-1:0] ratio_r;

  logic         ev_push;
  arsc_event_t  ev_in;
  logic         cmd_full;
  logic         cmd_empty;
  arsc_event_t  ev_head;
  logic         ev_pop;
  logic         res_full;
  logic         res_push;
  arsc_result_t res_in;
  arsc_result_t res_head;

  assign cfg_ready = 1'b1;
  assign in_full   = cmd_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accurate_r <= 1'b0;
      ratio_r    <= RATIO_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACCURATE: accurate_r <= cfg_data[0];
        REG_RATIO:    ratio_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  arsc_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .dot_kind (in_dot_kind),
    .q_full   (cmd_full),
    .ev_push  (ev_push),
    .ev       (ev_in)
  );

  arsc_queue #(
    .WIDTH ($bits(arsc_event_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (ev_push),
    .wr_data (ev_in),
    .full    (cmd_full),
    .pop     (ev_pop),
    .rd_data (ev_head),
    .empty   (cmd_empty)
  );

  arsc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_accurate (accurate_r),
    .cfg_ratio    (ratio_r),
    .ev_empty     (cmd_empty),
    .ev           (ev_head),
    .ev_pop       (ev_pop),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res_in)
  );

  arsc_queue #(
    .WIDTH ($bits(arsc_result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_head),
    .empty   (out_empty)
  );

  assign out_char_code     = res_head.char_code;
  assign out_repeat_count  = res_head.repeat_count;
  assign out_last_of_burst = res_head.last_of_burst;

endmodule

### rtl/arsc_queue.sv
// ----------------------------------------------------------------------------
// arsc_queue
// small register based fifo with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module arsc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/arsc_front.sv
// ----------------------------------------------------------------------------
// arsc_front
// dot classifier: tracks the current run, emits run end and blank line events
// ----------------------------------------------------------------------------
module arsc_front
  import arsc_pkg::*;
#(
  parameter int MAX_RUN = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  dot_kind_t   dot_kind,
  input  logic        q_full,
  output logic        ev_push,
  output arsc_event_t ev
);

  dot_kind_t        kind;
  logic             accept;
  dot_kind_t        prev_r;
  dot_kind_t        prev_nxt;
  logic [RUN_W-1:0] run_len_r;
  logic [RUN_W-1:0] run_len_nxt;
  logic             line_first_r;
  logic             line_first_nxt;

  assign kind   = (dot_kind == KIND_ALT) ? KIND_EOL : dot_kind;
  assign accept = push && !q_full;

  always_comb begin
    prev_nxt       = prev_r;
    run_len_nxt    = run_len_r;
    line_first_nxt = line_first_r;
    ev_push        = 1'b0;
    ev.nl_only     = 1'b0;
    ev.first       = line_first_r;
    ev.prev_black  = (prev_r == KIND_BLACK);
    ev.next_black  = (kind == KIND_BLACK);
    ev.eol         = (kind == KIND_EOL);
    ev.run_len     = run_len_r;
    if (accept) begin
      priority if (kind == prev_r) begin
        if (kind == KIND_EOL) begin
          // blank line
          ev_push    = 1'b1;
          ev.nl_only = 1'b1;
        end else if (run_len_r < RUN_W'(MAX_RUN)) begin
          run_len_nxt = run_len_r + 1'b1;
        end
      end else if (prev_r == KIND_EOL) begin
        // first dot of a line, carry restarts at zero
        run_len_nxt    = RUN_W'(1);
        line_first_nxt = 1'b1;
        prev_nxt       = kind;
      end else begin
        ev_push        = 1'b1;
        line_first_nxt = 1'b0;
        run_len_nxt    = (kind == KIND_EOL) ? '0 : RUN_W'(1);
        prev_nxt       = kind;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r       <= KIND_EOL;
      run_len_r    <= '0;
      line_first_r <= 1'b0;
    end else begin
      prev_r       <= prev_nxt;
      run_len_r    <= run_len_nxt;
      line_first_r <= line_first_nxt;
    end
  end

endmodule

### rtl/arsc_back.sv
// ----------------------------------------------------------------------------
// arsc_back
// run scaling: multiply stage, carry and rounding stage, result burst emitter
// ----------------------------------------------------------------------------
`include "aspect_ratio_run_scaler_top_macros.svh"

module arsc_back
  import arsc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_accurate,
  input  logic [RATIO_W-1:0] cfg_ratio,
  input  logic               ev_empty,
  input  arsc_event_t        ev,
  output logic               ev_pop,
  input  logic               res_full,
  output logic               res_push,
  output arsc_result_t       res
);

  localparam int PAD = FRAC_MAX - 16;
  localparam int SHR = FRAC_MAX - FRAC_BITS;
  localparam int RW  = FRAC_BITS + 2;
  localparam int PW  = RW + RUN_W;
  localparam int VW  = PW + 1;
  localparam int CW  = FRAC_BITS + 1;
  localparam int NW  = VW - FRAC_BITS;
  localparam longint unsigned ONE_L  = 64'd1 << FRAC_BITS;
  localparam longint unsigned T_HI_L = (64'd66666 * ONE_L + 64'd99999) / 64'd100000;
  localparam longint unsigned T_LO_L = (64'd33333 * ONE_L + 64'd99999) / 64'd100000;
  localparam logic [FRAC_BITS-1:0] T_HI = FRAC_BITS'(T_HI_L);
  localparam logic [FRAC_BITS-1:0] T_LO = FRAC_BITS'(T_LO_L);
  localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(ONE_L >> 1);

  logic [RATIO_W+PAD-1:0] ratio_wide;
  logic [RW-1:0]          ratio_s;

  // multiply stage
  logic              m_vld_r;
  arsc_event_t       m_ev_r;
  logic [PW-1:0]     m_prod_r;

  // rounding stage
  logic signed [CW-1:0] carry_r;
  logic signed [CW-1:0] carry_eff;
  logic signed [CW-1:0] carry_nxt;
  logic signed [VW-1:0] v;
  logic                 v_neg;
  logic [FRAC_BITS-1:0] frac;
  logic [NW-1:0]        n_int;
  logic [NW-1:0]        n_fin;
  logic [CNT_W-1:0]     cnt_sat;
  logic                 rnd_up;
  logic                 third;
  logic                 half_r;
  logic                 half_l;
  logic [CHAR_W-1:0]    run_ch;
  arsc_slot_t           slots [3];
  logic [1:0]           slot_n;
  logic                 a_load;

  // burst emitter
  arsc_slot_t b_slot_r [3];
  logic [1:0] b_cnt_r;

  assign ratio_wide = {cfg_ratio, {PAD{1'b0}}};
  assign ratio_s    = RW'(ratio_wide >> SHR);

  assign res_push = (b_cnt_r != 2'd0) && !res_full;
  assign res.char_code     = b_slot_r[0].char_code;
  assign res.repeat_count  = b_slot_r[0].repeat_count;
  assign res.last_of_burst = (b_cnt_r == 2'd1);

  assign a_load = m_vld_r && ((b_cnt_r == 2'd0) || ((b_cnt_r == 2'd1) && res_push));
  assign ev_pop = !ev_empty && (!m_vld_r || a_load);

  assign carry_eff = m_ev_r.first ? '0 : carry_r;
  assign v         = $signed({1'b0, m_prod_r}) + VW'(carry_eff);
  assign v_neg     = v[VW-1];
  assign frac      = v[FRAC_BITS-1:0];
  // a negative sum is above minus one, so its integer part is zero
  assign n_int     = v_neg ? '0 : {1'b0, v[VW-2:FRAC_BITS]};

  always_comb begin
    rnd_up = 1'b0;
    third  = 1'b0;
    if (!v_neg) begin
      if (cfg_accurate) begin
        rnd_up = (frac >= T_HI);
        third  = (frac >= T_LO) && (frac < T_HI);
      end else begin
        rnd_up = (frac >= HALF);
      end
    end
  end

  always_comb begin
    if (v_neg) begin
      carry_nxt = v[CW-1:0];
    end else if (rnd_up || third) begin
      carry_nxt = $signed({1'b1, frac});  // frac minus one
    end else begin
      carry_nxt = $signed({1'b0, frac});
    end
  end

  assign n_fin   = n_int + NW'(rnd_up);
  assign cnt_sat = (n_fin > NW'(COUNT_MAX)) ? COUNT_MAX : n_fin[CNT_W-1:0];
  assign half_r  = third && m_ev_r.prev_black;
  assign half_l  = third && !m_ev_r.prev_black && m_ev_r.next_black;
  assign run_ch  = !m_ev_r.prev_black ? CH_SPACE : (cfg_accurate ? CH_OH : CH_HASH);

  always_comb begin
    slots[0] = '0;
    slots[1] = '0;
    slots[2] = '0;
    slot_n   = 2'd0;
    if (m_ev_r.nl_only) begin
      slots[0] = '{char_code: CH_NL, repeat_count: CNT_W'(1)};
      slot_n   = 2'd1;
    end else begin
      if (n_fin != '0) begin
        slots[slot_n] = '{char_code: run_ch, repeat_count: cnt_sat};
        slot_n        = slot_n + 1'b1;
      end
      if (half_r || half_l) begin
        slots[slot_n] = '{char_code: half_r ? CH_RPAR : CH_LPAR, repeat_count: CNT_W'(1)};
        slot_n        = slot_n + 1'b1;
      end
      if (m_ev_r.eol) begin
        slots[slot_n] = '{char_code: CH_NL, repeat_count: CNT_W'(1)};
        slot_n        = slot_n + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      b_cnt_r <= 2'd0;
      carry_r <= '0;
    end else begin
      if (ev_pop) begin
        m_vld_r <= 1'b1;
      end else if (a_load) begin
        m_vld_r <= 1'b0;
      end
      if (a_load) begin
        b_cnt_r <= slot_n;
        if (!m_ev_r.nl_only) begin
          carry_r <= carry_nxt;
        end
      end else if (res_push) begin
        b_cnt_r <= b_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop) begin
      m_ev_r   <= ev;
      m_prod_r <= PW'(ratio_s) * PW'(ev.run_len);
    end
    if (a_load) begin
      b_slot_r[0] <= slots[0];
      b_slot_r[1] <= slots[1];
      b_slot_r[2] <= slots[2];
    end else if (res_push) begin
      b_slot_r[0] <= b_slot_r[1];
      b_slot_r[1] <= b_slot_r[2];
    end
  end

  `ARSC_ASSERT_STALL(a_mul_hold, m_vld_r && !a_load, m_prod_r)
  `ARSC_ASSERT_STALL(a_burst_hold, (b_cnt_r != 2'd0) && res_full, b_cnt_r)
  `ARSC_ASSERT(a_blank_carry, (a_load && m_ev_r.nl_only) |=> $stable(carry_r))
  `ARSC_ASSERT(a_blank_one, (a_load && m_ev_r.nl_only) |=> (b_cnt_r == 2'd1))

endmodule

### test/aspect_ratio_run_scaler_top_tb.sv
// ----------------------------------------------------------------------------
// aspect_ratio_run_scaler_top_tb
// drives dot streams into the run scaler and checks every character run
// against a behavioral scaler kept in step with each accepted dot; covers
// blank lines, both rounding styles, ratio extremes, long runs and random
// lines under sender and receiver stalls
// ----------------------------------------------------------------------------
module aspect_ratio_run_scaler_top_tb;
  import arsc_pkg::*;

  localparam int MAX_RUN       = 255;
  localparam int FRAC_BITS     = 16;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [RATIO_W-1:0]   RATIO_MAX  = 18'h3FFFF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  dot_kind_t            in_dot_kind = KIND_WHITE;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [CHAR_W-1:0]    out_char_code;
  logic [CNT_W-1:0]     out_repeat_count;
  logic                 out_last_of_burst;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ACCURATE;
  logic [RATIO_W-1:0]   cfg_data = '0;

  aspect_ratio_run_scaler_top #(
    .MAX_RUN   (MAX_RUN),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_dot_kind       (in_dot_kind),
    .in_full           (in_full),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_char_code     (out_char_code),
    .out_repeat_count  (out_repeat_count),
    .out_last_of_burst (out_last_of_burst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scaler state and registers as seen by the testbench
  dot_kind_t          last_kind = KIND_EOL;
  int                 run_len = 0;
  longint             carry_frac = 0;
  bit                 style_accurate = 1'b0;
  logic [RATIO_W-1:0] ratio_q16 = RATIO_RESET;

  arsc_result_t expected_glyphs[$];
  arsc_result_t want;
  int           errors = 0;
  int           dots_sent = 0;
  int           cycles = 0;
  int           send_idle_pct = 15;
  int           recv_idle_pct = 69;

  function automatic void predict_glyphs(input dot_kind_t raw);
    dot_kind_t         kind;
    longint            one, half, t_hi, t_lo, ratio_fx, v, n, rem, m;
    logic [CHAR_W-1:0] ch;
    bit                rpar, lpar;
    arsc_result_t      r;
    arsc_result_t      burst[$];
    kind = (raw == KIND_ALT) ? KIND_EOL : raw;
    if (kind == last_kind) begin
      if (kind == KIND_EOL) begin
        r = '{char_code: CH_NL, repeat_count: 10'd1, last_of_burst: 1'b1};
        expected_glyphs.push_back(r);
      end else if (run_len < MAX_RUN) begin
        run_len++;
      end
      return;
    end
    // first dot of a line only opens a run
    if (last_kind == KIND_EOL) begin
      run_len = 1;
      carry_frac = 0;
      last_kind = kind;
      return;
    end
    one  = longint'(1) << FRAC_BITS;
    half = one >> 1;
    t_hi = ((longint'(66666) << FRAC_BITS) + 99999) / 100000;
    t_lo = ((longint'(33333) << FRAC_BITS) + 99999) / 100000;
    ratio_fx = (FRAC_BITS >= 16) ? (longint'(ratio_q16) << (FRAC_BITS - 16))
                                 : (longint'(ratio_q16) >> (16 - FRAC_BITS));
    v = ratio_fx * run_len + carry_frac;
    // integer part truncates toward zero, remainder keeps the sign
    if (v >= 0) begin
      n   = v >> FRAC_BITS;
      rem = v & (one - 1);
    end else begin
      m   = -v;
      n   = -(m >> FRAC_BITS);
      rem = -(m & (one - 1));
    end
    rpar = 1'b0;
    lpar = 1'b0;
    if (style_accurate) begin
      if (rem >= t_hi) begin
        n++;
        rem -= one;
      end else if (rem >= t_lo) begin
        if (last_kind == KIND_BLACK) rpar = 1'b1;
        else if (kind == KIND_BLACK) lpar = 1'b1;
        rem -= one;
      end
      ch = (last_kind == KIND_BLACK) ? CH_OH : CH_SPACE;
    end else begin
      if (rem >= half) begin
        n++;
        rem -= one;
      end
      ch = (last_kind == KIND_BLACK) ? CH_HASH : CH_SPACE;
    end
    carry_frac = rem;
    if (n > 0) begin
      r.char_code     = ch;
      r.repeat_count  = (n > longint'(COUNT_MAX)) ? COUNT_MAX : n[CNT_W-1:0];
      r.last_of_burst = 1'b0;
      burst.push_back(r);
    end
    if (rpar) begin
      r = '{char_code: CH_RPAR, repeat_count: 10'd1, last_of_burst: 1'b0};
      burst.push_back(r);
    end else if (lpar) begin
      r = '{char_code: CH_LPAR, repeat_count: 10'd1, last_of_burst: 1'b0};
      burst.push_back(r);
    end
    if (kind == KIND_EOL) begin
      r = '{char_code: CH_NL, repeat_count: 10'd1, last_of_burst: 1'b0};
      burst.push_back(r);
      run_len = 0;
    end else begin
      run_len = 1;
    end
    last_kind = kind;
    if (burst.size() > 0) burst[burst.size()-1].last_of_burst = 1'b1;
    foreach (burst[i]) expected_glyphs.push_back(burst[i]);
  endfunction

  task automatic send_dot(input dot_kind_t kind);
    in_push     <= 1'b1;
    in_dot_kind <= kind;
    do @(posedge clk); while (in_full);
    predict_glyphs(kind);
    dots_sent++;
    // each sender cycle idles with the set chance
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // leaves cfg_valid high so back to back writes need no second assignment
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATIO_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ACCURATE) style_accurate = data[0];
    else if (idx == REG_RATIO) ratio_q16 = data;
  endtask

  task automatic set_style_ratio(input bit acc, input logic [RATIO_W-1:0] ratio);
    write_reg(REG_ACCURATE, {17'($urandom), acc});
    write_reg(REG_RATIO, ratio);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_results_done();
    if (expected_glyphs.size() != 0) begin
      in_push <= 1'b0;
      while (expected_glyphs.size() != 0) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_blank_lines();
    send_dot(KIND_EOL);
    send_dot(KIND_EOL);
    send_dot(KIND_ALT);
    send_dot(KIND_WHITE);
    send_dot(KIND_ALT);
    drain();
  endtask

  task automatic test_compact_runs();
    send_dot(KIND_WHITE);
    send_dot(KIND_WHITE);
    send_dot(KIND_BLACK);
    send_dot(KIND_BLACK);
    send_dot(KIND_WHITE);
    send_dot(KIND_EOL);
    drain();
  endtask

  task automatic test_accurate_halves();
    set_style_ratio(1'b1, RATIO_RESET);
    send_dot(KIND_BLACK);
    send_dot(KIND_WHITE);
    send_dot(KIND_BLACK);
    send_dot(KIND_BLACK);
    send_dot(KIND_WHITE);
    send_dot(KIND_EOL);
    drain();
  endtask

  task automatic test_ratio_extremes();
    // a round-up leaves a negative carry, then a zero ratio keeps it negative
    set_style_ratio(1'b0, RATIO_RESET);
    send_dot(KIND_WHITE);
    send_dot(KIND_BLACK);
    drain();
    set_style_ratio(1'b1, '0);
    send_dot(KIND_WHITE);
    send_dot(KIND_BLACK);
    send_dot(KIND_EOL);
    drain();
    set_style_ratio(1'b0, 18'd1);
    send_dot(KIND_BLACK);
    send_dot(KIND_WHITE);
    send_dot(KIND_EOL);
    drain();
    set_style_ratio(1'b1, RATIO_MAX);
    send_dot(KIND_WHITE);
    send_dot(KIND_BLACK);
    send_dot(KIND_WHITE);
    send_dot(KIND_EOL);
    drain();
  endtask

  task automatic test_unknown_register();
    write_reg(REG_SPARE2, 18'h15555);
    write_reg(REG_SPARE3, 18'h2AAAA);
    cfg_valid <= 1'b0;
    send_dot(KIND_BLACK);
    send_dot(KIND_WHITE);
    send_dot(KIND_EOL);
    drain();
  endtask

  task automatic test_run_saturation();
    set_style_ratio(1'b0, RATIO_MAX);
    repeat (MAX_RUN + 3) send_dot(KIND_BLACK);
    send_dot(KIND_WHITE);
    send_dot(KIND_EOL);
    drain();
  endtask

  task automatic random_line();
    int        runs;
    int        len;
    dot_kind_t kind;
    if ($urandom_range(99) < 12) begin
      // noise: any kind in any order
      repeat ($urandom_range(1, 8)) send_dot(dot_kind_t'($urandom_range(3)));
    end else begin
      runs = $urandom_range(0, 6);
      kind = dot_kind_t'($urandom_range(1));
      repeat (runs) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
        repeat (len) send_dot(kind);
        kind = (kind == KIND_WHITE) ? KIND_BLACK : KIND_WHITE;
      end
      send_dot(($urandom_range(4) == 0) ? KIND_ALT : KIND_EOL);
    end
    if ($urandom_range(39) == 0) wait_results_done();
  endtask

  task automatic test_random_lines(input int n_dots, input bit acc,
                                   input logic [RATIO_W-1:0] ratio);
    int start;
    start = dots_sent;
    set_style_ratio(acc, ratio);
    random_line();
    wait_results_done();
    while (dots_sent - start < n_dots) random_line();
    drain();
  endtask

  // receiver side
  always @(posedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_glyphs.size() == 0) begin
        $error("unexpected item: char_code %0d repeat_count %0d", out_char_code,
               out_repeat_count);
        errors++;
      end else begin
        want = expected_glyphs.pop_front();
        if (out_char_code !== want.char_code) begin
          $error("char_code expected %0d actual %0d", want.char_code, out_char_code);
          errors++;
        end
        if (out_repeat_count !== want.repeat_count) begin
          $error("repeat_count expected %0d actual %0d", want.repeat_count,
                 out_repeat_count);
          errors++;
        end
        if (out_last_of_burst !== want.last_of_burst) begin
          $error("last_of_burst expected %0d actual %0d", want.last_of_burst,
                 out_last_of_burst);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_blank_lines();
    test_compact_runs();
    test_accurate_halves();
    test_ratio_extremes();
    test_unknown_register();
    test_run_saturation();
    test_random_lines(50, 1'b0, RATIO_RESET);
    send_idle_pct = 69;
    recv_idle_pct = 15;
    test_random_lines(50, 1'b1, 18'($urandom_range(40000, 200000)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_lines(50, 1'($urandom_range(1)), 18'($urandom_range(1, RATIO_MAX)));
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
